// ===== hdl/tnns_pkg.sv =====
// Shared types and constants of the tree node nearest search core.
// Used by every module of the block except tnns_fifo; depends on nothing.
`default_nettype none
package tnns_pkg;

    localparam int COORD_W     = 16;
    localparam int IDX_OUT_W   = 12;
    localparam int COST_W      = 32;
    localparam int RADIUS_W    = 16;
    localparam int ABS_W       = COORD_W;
    localparam int SQ_W        = 2 * ABS_W;
    localparam int D2_W        = SQ_W + 2;
    localparam int ROOT_W      = D2_W / 2;
    localparam int NEAR_CNT_W  = 6;
    localparam int CFG_IDX_W   = 2;

    localparam int DEF_MAX_NODES = 4096;
    localparam int DEF_MAX_NEAR  = 63;
    localparam int CMD_Q_DEPTH   = 2;
    localparam int RES_Q_DEPTH   = 4;

    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_ADD     = 2'd1,
        FUNC_NEAREST = 2'd2,
        FUNC_NEAR    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_PAR = 2'd2,
        ST_TRUNC   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GOAL_X   = 2'd0,
        REG_GOAL_Y   = 2'd1,
        REG_GOAL_Z   = 2'd2,
        REG_GOAL_THR = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_func                      func;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  pos_z;
        logic [IDX_OUT_W-1:0]       parent_index;
        logic [RADIUS_W-1:0]        radius;
    } t_item;

    typedef struct packed {
        logic                       found;
        logic [IDX_OUT_W-1:0]       node_index;
        logic signed [COORD_W-1:0]  node_x;
        logic signed [COORD_W-1:0]  node_y;
        logic signed [COORD_W-1:0]  node_z;
        logic [COST_W-1:0]          node_cost;
        logic                       goal_reached;
        logic                       last_result;
        t_status                    status;
    } t_result;

    // Classified request handed from the front to the back.
    typedef struct packed {
        t_func                      func;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  pos_z;
        logic [IDX_OUT_W-1:0]       parent_index;
        logic [2*RADIUS_W-1:0]      radius_sq;
    } t_cmd;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic [RADIUS_W-1:0]        threshold;
    } t_goal;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic [COST_W-1:0]          cost;
    } t_node;

    function automatic logic [ABS_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[ABS_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/tnns_fifo.sv =====
// Small synchronous queue used between the front and back and on the result side.
// Depends on nothing; width and depth come from parameters.
`default_nettype none
module tnns_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/tnns_front.sv =====
// Front end: takes input items, squares the near radius, and queues requests.
// Depends on tnns_pkg and tnns_fifo.
`default_nettype none
module tnns_front
    import tnns_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_cmd_pop,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);
    logic  r_valid;
    t_cmd  r_cmd;
    logic  q_full;
    logic  accept;
    logic [$bits(t_cmd)-1:0] q_data;

    assign o_full = r_valid && q_full;
    assign accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!q_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.func         <= i_item.func;
            r_cmd.pos_x        <= i_item.pos_x;
            r_cmd.pos_y        <= i_item.pos_y;
            r_cmd.pos_z        <= i_item.pos_z;
            r_cmd.parent_index <= i_item.parent_index;
            r_cmd.radius_sq    <= i_item.radius * i_item.radius;
        end
    end

    tnns_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_valid),
        .i_data  (r_cmd),
        .o_full  (q_full),
        .i_pop   (i_cmd_pop),
        .o_valid (o_cmd_valid),
        .o_data  (q_data)
    );

    assign o_cmd = t_cmd'(q_data);
endmodule
`default_nettype wire

// ===== hdl/tnns_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on tnns_pkg.
`default_nettype none
module tnns_isqrt
    import tnns_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [D2_W-1:0] i_value,
    output logic                 o_done,
    output logic [ROOT_W-1:0]    o_root
);
    localparam int STEPS = ROOT_W;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [D2_W-1:0]   r_rem, r_root, r_bit;
    logic [D2_W:0]     trial;

    assign trial  = {1'b0, r_root} + {1'b0, r_bit};
    assign o_done = r_busy && (r_cnt == '0);
    assign o_root = r_root[ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= STEP_W'(STEPS);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_value;
            r_root <= '0;
            r_bit  <= D2_W'(1) << (2 * (STEPS - 1));
        end else if (r_busy && r_cnt != '0) begin
            if ({1'b0, r_rem} >= trial) begin
                r_rem  <= r_rem - trial[D2_W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/tnns_back.sv =====
// Back end: node memory, distance scan pipeline, goal check and result building.
// Depends on tnns_pkg and tnns_isqrt.
`default_nettype none
module tnns_back
    import tnns_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_NEAR  = DEF_MAX_NEAR
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cmd_valid,
    input  wire t_cmd    i_cmd,
    output logic         o_cmd_pop,
    input  wire t_goal   i_goal,
    output logic         o_res_push,
    output t_result      o_res,
    input  wire logic    i_res_full
);
    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int SETTLE = 4;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SQRT, S_SETTLE, S_EMIT
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_addr, r_end;
    logic             r_stop;
    logic [2:0]       r_settle;

    // Node memory
    t_node      r_mem [MAX_NODES];
    t_node      r_rd;
    logic       wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_node      wr_data;

    // Scan pipeline
    logic       adv, issue;
    logic       r_s1_v, r_s2_v, r_s3_v;
    logic [IDX_W-1:0] r_s1_idx, r_s2_idx, r_s3_idx;
    t_node      r_s2_node, r_s3_node;
    logic [ABS_W-1:0] r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]  r_sx, r_sy, r_sz;
    logic [D2_W-1:0]  d2;

    // Nearest and near bookkeeping
    logic             r_first;
    logic [D2_W-1:0]  r_bd;
    logic [IDX_W-1:0] r_best_idx;
    t_node            r_best;
    logic [NEAR_CNT_W-1:0] r_k;
    logic             r_trunc;
    logic             r_pend_v;
    logic [IDX_W-1:0] r_pend_idx;
    t_node            r_pend;
    logic             near_hit;

    // Add path
    logic             r_sq_start;
    logic [D2_W-1:0]  r_sq_in;
    logic [COST_W-1:0] r_par_cost;
    logic             sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic [COST_W:0]  cost_sum;
    logic [COST_W-1:0] new_cost;

    // Goal check pipeline
    logic signed [COORD_W-1:0] r_new_x, r_new_y, r_new_z;
    logic [ABS_W-1:0] r_gdx, r_gdy, r_gdz;
    logic [SQ_W-1:0]  r_gsx, r_gsy, r_gsz;
    logic [RADIUS_W-1:0] r_gt;
    logic [2*RADIUS_W-1:0] r_gt2;
    logic             r_g1_ne, r_g2_ne, r_goal_hit;
    logic [D2_W-1:0]  gd2;

    t_result r_res;

    function automatic t_result make_res(logic found, logic [IDX_W-1:0] idx,
                                         t_node nd, t_status st);
        t_result r;
        r = '0;
        r.status = st;
        if (found) begin
            r.found      = 1'b1;
            r.node_index = IDX_OUT_W'(32'(idx));
            r.node_x     = nd.x;
            r.node_y     = nd.y;
            r.node_z     = nd.z;
            r.node_cost  = nd.cost;
        end
        return r;
    endfunction

    assign d2 = D2_W'(r_sx) + D2_W'(r_sy) + D2_W'(r_sz);
    assign near_hit = r_s3_v && !r_stop && (r_cmd.func == FUNC_NEAR)
                      && (d2 < D2_W'(r_cmd.radius_sq));
    assign adv   = !((r_state == S_SCAN) && (r_cmd.func == FUNC_NEAR) && i_res_full);
    assign issue = (r_state == S_SCAN) && adv && !r_stop && (r_addr != r_end);

    assign cost_sum = {1'b0, r_par_cost} + (COST_W + 1)'(sq_root);
    assign new_cost = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IDX_W-1:0];
        wr_data = '{x: r_cmd.pos_x, y: r_cmd.pos_y, z: r_cmd.pos_z, cost: new_cost};
        if (o_cmd_pop && i_cmd.func == FUNC_START) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '{x: i_cmd.pos_x, y: i_cmd.pos_y, z: i_cmd.pos_z, cost: '0};
        end else if (r_state == S_SQRT && sq_done) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (adv) begin
            r_rd <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

    // Result push: near matches stream out while scanning, all else in S_EMIT
    always_comb begin
        o_res_push = 1'b0;
        o_res      = make_res(1'b1, r_pend_idx, r_pend, ST_OK);
        if (r_state == S_EMIT) begin
            o_res_push = !i_res_full;
            o_res      = r_res;
            o_res.last_result = 1'b1;
        end else if (near_hit && adv && r_pend_v && r_k != NEAR_CNT_W'(MAX_NEAR)) begin
            o_res_push = 1'b1;
        end
        o_res.goal_reached = r_goal_hit;
    end

    // Scan pipeline data path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_idx  <= r_addr[IDX_W-1:0];
            r_s2_idx  <= r_s1_idx;
            r_s2_node <= r_rd;
            r_dx      <= abs_diff(r_cmd.pos_x, r_rd.x);
            r_dy      <= abs_diff(r_cmd.pos_y, r_rd.y);
            r_dz      <= abs_diff(r_cmd.pos_z, r_rd.z);
            r_s3_idx  <= r_s2_idx;
            r_s3_node <= r_s2_node;
            r_sx      <= r_dx * r_dx;
            r_sy      <= r_dy * r_dy;
            r_sz      <= r_dz * r_dz;
        end
    end

    // Goal check: recomputed every cycle from the newest node and the goal
    assign gd2 = D2_W'(r_gsx) + D2_W'(r_gsy) + D2_W'(r_gsz);

    always_ff @(posedge i_clk) begin
        r_gdx   <= abs_diff(r_new_x, i_goal.x);
        r_gdy   <= abs_diff(r_new_y, i_goal.y);
        r_gdz   <= abs_diff(r_new_z, i_goal.z);
        r_gt    <= i_goal.threshold;
        r_g1_ne <= (r_count != '0);
        r_gsx   <= r_gdx * r_gdx;
        r_gsy   <= r_gdy * r_gdy;
        r_gsz   <= r_gdz * r_gdz;
        r_gt2   <= r_gt * r_gt;
        r_g2_ne <= r_g1_ne;
        r_goal_hit <= r_g2_ne && (gd2 < D2_W'(r_gt2));
    end

    tnns_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_value (r_sq_in),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_stop     <= 1'b0;
            r_settle   <= '0;
            r_sq_start <= 1'b0;
            r_pend_v   <= 1'b0;
            r_first    <= 1'b0;
            r_k        <= '0;
            r_trunc    <= 1'b0;
            r_addr     <= '0;
            r_end      <= '0;
            r_new_x    <= '0;
            r_new_y    <= '0;
            r_new_z    <= '0;
        end else begin
            r_sq_start <= 1'b0;
            if (issue) begin
                r_addr <= r_addr + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd    <= i_cmd;
                        r_stop   <= 1'b0;
                        r_first  <= 1'b1;
                        r_k      <= '0;
                        r_trunc  <= 1'b0;
                        r_pend_v <= 1'b0;
                        r_settle <= 3'(SETTLE);
                        unique case (i_cmd.func)
                            FUNC_START: begin
                                r_count <= CNT_W'(1);
                                r_new_x <= i_cmd.pos_x;
                                r_new_y <= i_cmd.pos_y;
                                r_new_z <= i_cmd.pos_z;
                                r_res   <= make_res(1'b1, '0,
                                    '{x: i_cmd.pos_x, y: i_cmd.pos_y, z: i_cmd.pos_z,
                                      cost: '0}, ST_OK);
                                r_state <= S_SETTLE;
                            end
                            FUNC_ADD: begin
                                if (r_count == CNT_W'(MAX_NODES)) begin
                                    r_res   <= make_res(1'b0, '0, '0, ST_FULL);
                                    r_state <= S_SETTLE;
                                end else if (32'(i_cmd.parent_index) >= 32'(r_count)) begin
                                    r_res   <= make_res(1'b0, '0, '0, ST_BAD_PAR);
                                    r_state <= S_SETTLE;
                                end else begin
                                    r_addr  <= CNT_W'(32'(i_cmd.parent_index));
                                    r_end   <= CNT_W'(32'(i_cmd.parent_index) + 1);
                                    r_state <= S_SCAN;
                                end
                            end
                            FUNC_NEAREST, FUNC_NEAR: begin
                                if (r_count == '0) begin
                                    r_res   <= make_res(1'b0, '0, '0, ST_OK);
                                    r_state <= S_SETTLE;
                                end else begin
                                    r_addr  <= '0;
                                    r_end   <= r_count;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_cmd.func == FUNC_ADD) begin
                        if (r_s3_v) begin
                            r_sq_in    <= d2;
                            r_par_cost <= r_s3_node.cost;
                            r_sq_start <= 1'b1;
                            r_state    <= S_SQRT;
                        end
                    end else begin
                        if (adv && r_s3_v && !r_stop) begin
                            if (r_cmd.func == FUNC_NEAREST) begin
                                if (r_first || d2 < r_bd) begin
                                    r_bd       <= d2;
                                    r_best_idx <= r_s3_idx;
                                    r_best     <= r_s3_node;
                                end
                                r_first <= 1'b0;
                            end else if (near_hit) begin
                                if (r_k == NEAR_CNT_W'(MAX_NEAR)) begin
                                    r_trunc <= 1'b1;
                                    r_stop  <= 1'b1;
                                end else begin
                                    r_pend_v   <= 1'b1;
                                    r_pend_idx <= r_s3_idx;
                                    r_pend     <= r_s3_node;
                                    r_k        <= r_k + 1'b1;
                                end
                            end
                        end
                        // Finish once issue is over and the pipeline has drained
                        if ((r_stop || r_addr == r_end) && !r_s1_v && !r_s2_v && !r_s3_v) begin
                            if (r_cmd.func == FUNC_NEAREST) begin
                                r_res <= make_res(1'b1, r_best_idx, r_best, ST_OK);
                            end else if (r_pend_v) begin
                                r_res <= make_res(1'b1, r_pend_idx, r_pend,
                                                  r_trunc ? ST_TRUNC : ST_OK);
                            end else begin
                                r_res <= make_res(1'b0, '0, '0, ST_OK);
                            end
                            r_state <= S_SETTLE;
                        end
                    end
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_count <= r_count + 1'b1;
                        r_new_x <= r_cmd.pos_x;
                        r_new_y <= r_cmd.pos_y;
                        r_new_z <= r_cmd.pos_z;
                        r_res   <= make_res(1'b1, r_count[IDX_W-1:0], wr_data, ST_OK);
                        r_state <= S_SETTLE;
                    end
                end
                S_SETTLE: begin
                    // hold until the goal check reflects the newest node
                    if (r_settle == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_settle <= r_settle - 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/tree_node_nearest_search_core.sv =====
// Top level of the tree node nearest search core: config registers, front, back, result queue.
// Depends on tnns_pkg, tnns_front, tnns_back and tnns_fifo.
//
//  channel   direction  handshake             payload
//  item      in         i_push / o_full       i_item (t_item)
//  result    out        o_empty / i_pop       o_result (t_result)
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Start, rejected adds and queries on an empty tree go straight to the settle and emit states;
// an accepted add first scans its parent and waits on the one-bit-per-cycle square root.
// Queries scan the stored nodes, one node per cycle from the node memory's own read port.
// A near query stalls its scan while the result queue is full.
// Reset clears control state and loads the goal defaults; the node memory needs no clearing pass.
`default_nettype none
module tree_node_nearest_search_core
    import tnns_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_NEAR  = DEF_MAX_NEAR
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire t_item                i_item,
    output logic                      o_full,
    input  wire logic                 i_pop,
    output logic                      o_empty,
    output t_result                   o_result,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [RADIUS_W-1:0]  i_cfg_data
);
    t_goal   r_goal;
    logic    cmd_valid, cmd_pop;
    t_cmd    cmd;
    logic    res_push, res_full, res_valid;
    t_result res;
    logic [$bits(t_result)-1:0] res_q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal.x         <= '0;
            r_goal.y         <= '0;
            r_goal.z         <= '0;
            r_goal.threshold <= RADIUS_W'(256);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_GOAL_X:   r_goal.x         <= i_cfg_data;
                REG_GOAL_Y:   r_goal.y         <= i_cfg_data;
                REG_GOAL_Z:   r_goal.z         <= i_cfg_data;
                REG_GOAL_THR: r_goal.threshold <= i_cfg_data;
                default:      r_goal           <= r_goal;
            endcase
        end
    end

    tnns_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    tnns_back #(
        .MAX_NODES (MAX_NODES),
        .MAX_NEAR  (MAX_NEAR)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_goal      (r_goal),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    tnns_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_valid (res_valid),
        .o_data  (res_q_data)
    );

    assign o_empty  = !res_valid;
    assign o_result = t_result'(res_q_data);

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_result.found) |->
            (o_result.node_index == '0 && o_result.node_cost == '0 && o_result.last_result))
        else $error("result without node carries data or is not final");

    a_reject_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_result.status == ST_FULL || o_result.status == ST_BAD_PAR)) |->
            (!o_result.found && o_result.last_result))
        else $error("rejected add reported a node");

    a_trunc_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.status == ST_TRUNC) |-> (o_result.found && o_result.last_result))
        else $error("truncated near list flag on a non-final result");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_result)))
        else $error("waiting result changed without pop");
endmodule
`default_nettype wire

// ===== dv/tb_tree_node_nearest_search_core.sv =====
// Self-checking bench for tree_node_nearest_search_core: directed and random requests,
// a tree predictor kept in the bench, and an in-order result scoreboard.
// Depends on tnns_pkg and the core RTL only.
`default_nettype none
module tb_tree_node_nearest_search_core;
    timeunit 1ns;
    timeprecision 1ps;
    import tnns_pkg::*;

    localparam int TREE_DEPTH = DEF_MAX_NODES;
    localparam int NEAR_CAP   = DEF_MAX_NEAR;
    localparam int STALL_MAX  = 20000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_push;
    t_item                i_item;
    logic                 o_full;
    logic                 i_pop;
    logic                 o_empty;
    t_result              o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [RADIUS_W-1:0]  i_cfg_data;

    tree_node_nearest_search_core DUT (.*);

    // Predicted tree
    logic signed [COORD_W-1:0] tree_x [TREE_DEPTH];
    logic signed [COORD_W-1:0] tree_y [TREE_DEPTH];
    logic signed [COORD_W-1:0] tree_z [TREE_DEPTH];
    logic [COST_W-1:0]         tree_cost [TREE_DEPTH];
    int                        tree_count;
    int                        tree_newest;
    logic signed [COORD_W-1:0] goal_px, goal_py, goal_pz;
    logic [RADIUS_W-1:0]       goal_thr;

    t_result pending_results[$];
    int      fail_count;
    int      idle_cycles;
    logic    hold_off;
    int      burst_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned dist_sq(logic signed [COORD_W-1:0] ax, ay, az,
                                                logic signed [COORD_W-1:0] bx, by, bz);
        longint dx, dy, dz;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        dz = longint'(az) - longint'(bz);
        return longint'(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    function automatic logic goal_hit();
        longint unsigned t;
        t = goal_thr;
        if (tree_count == 0) return 1'b0;
        return dist_sq(tree_x[tree_newest], tree_y[tree_newest], tree_z[tree_newest],
                       goal_px, goal_py, goal_pz) < t * t;
    endfunction

    function automatic t_result node_result(logic found, int idx, t_status st);
        t_result r;
        r = '0;
        r.found = found;
        if (found) begin
            r.node_index = idx[IDX_OUT_W-1:0];
            r.node_x = tree_x[idx];
            r.node_y = tree_y[idx];
            r.node_z = tree_z[idx];
            r.node_cost = tree_cost[idx];
        end
        r.goal_reached = goal_hit();
        r.status = st;
        return r;
    endfunction

    // Apply one accepted request to the tree and queue what it must produce.
    task automatic predict_tree(t_item it);
        t_result outs[$];
        longint unsigned d, best_d, c, r2;
        int best;
        logic trunc;
        case (it.func)
            FUNC_START: begin
                tree_x[0] = it.pos_x; tree_y[0] = it.pos_y; tree_z[0] = it.pos_z;
                tree_cost[0] = '0;
                tree_count = 1;
                tree_newest = 0;
                outs.insert(outs.size(), node_result(1'b1, 0, ST_OK));
            end
            FUNC_ADD: begin
                if (tree_count >= TREE_DEPTH) begin
                    outs.insert(outs.size(), node_result(1'b0, 0, ST_FULL));
                end else if (int'(it.parent_index) >= tree_count) begin
                    outs.insert(outs.size(), node_result(1'b0, 0, ST_BAD_PAR));
                end else begin
                    d = floor_root(dist_sq(it.pos_x, it.pos_y, it.pos_z,
                                           tree_x[it.parent_index], tree_y[it.parent_index],
                                           tree_z[it.parent_index]));
                    c = tree_cost[it.parent_index] + d;
                    if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
                    tree_x[tree_count] = it.pos_x;
                    tree_y[tree_count] = it.pos_y;
                    tree_z[tree_count] = it.pos_z;
                    tree_cost[tree_count] = c[COST_W-1:0];
                    tree_newest = tree_count;
                    tree_count++;
                    outs.insert(outs.size(), node_result(1'b1, tree_newest, ST_OK));
                end
            end
            FUNC_NEAREST: begin
                if (tree_count == 0) begin
                    outs.insert(outs.size(), node_result(1'b0, 0, ST_OK));
                end else begin
                    best = 0;
                    best_d = dist_sq(it.pos_x, it.pos_y, it.pos_z, tree_x[0], tree_y[0],
                                     tree_z[0]);
                    for (int i = 1; i < tree_count; i++) begin
                        d = dist_sq(it.pos_x, it.pos_y, it.pos_z, tree_x[i], tree_y[i],
                                    tree_z[i]);
                        if (d < best_d) begin
                            best_d = d;
                            best = i;
                        end
                    end
                    outs.insert(outs.size(), node_result(1'b1, best, ST_OK));
                end
            end
            default: begin
                r2 = longint'(it.radius) * longint'(it.radius);
                trunc = 1'b0;
                for (int i = 0; i < tree_count; i++) begin
                    if (dist_sq(it.pos_x, it.pos_y, it.pos_z, tree_x[i], tree_y[i],
                                tree_z[i]) < r2) begin
                        if (outs.size() >= NEAR_CAP) begin
                            trunc = 1'b1;
                            break;
                        end
                        outs.insert(outs.size(), node_result(1'b1, i, ST_OK));
                    end
                end
                if (outs.size() == 0) outs.insert(0, node_result(1'b0, 0, ST_OK));
                else if (trunc) outs[outs.size() - 1].status = ST_TRUNC;
            end
        endcase
        outs[outs.size() - 1].last_result = 1'b1;
        foreach (outs[k]) pending_results.insert(pending_results.size(), outs[k]);
    endtask

    // Offer one request; called at a falling edge, returns at a falling edge.
    task automatic send_request(t_item it);
        i_push = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (o_full);
        predict_tree(it);
        @(negedge i_clk);
        i_push = 1'b0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
        // let any scan still running after its final result settle
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [RADIUS_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_GOAL_X: goal_px = val;
            REG_GOAL_Y: goal_py = val;
            REG_GOAL_Z: goal_pz = val;
            default:    goal_thr = val;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_item make_req(t_func f, int x, int y, int z, int par, int rad);
        t_item it;
        it.func = f;
        it.pos_x = x[COORD_W-1:0];
        it.pos_y = y[COORD_W-1:0];
        it.pos_z = z[COORD_W-1:0];
        it.parent_index = par[IDX_OUT_W-1:0];
        it.radius = rad[RADIUS_W-1:0];
        return it;
    endfunction

    // Mostly adds under valid parents and queries near the tree, some noise.
    function automatic t_item random_req();
        t_item it;
        int sel;
        sel = $urandom_range(0, 99);
        it.func = sel < 3 ? FUNC_START : sel < 55 ? FUNC_ADD :
                  sel < 77 ? FUNC_NEAREST : FUNC_NEAR;
        if ($urandom_range(0, 3) == 0) begin
            it.pos_x = 16'($urandom); it.pos_y = 16'($urandom); it.pos_z = 16'($urandom);
        end else begin
            it.pos_x = 16'($signed($urandom_range(0, 4095)) - 2048);
            it.pos_y = 16'($signed($urandom_range(0, 4095)) - 2048);
            it.pos_z = 16'($signed($urandom_range(0, 4095)) - 2048);
        end
        if ($urandom_range(0, 9) == 0 || tree_count == 0)
            it.parent_index = IDX_OUT_W'($urandom);
        else
            it.parent_index = IDX_OUT_W'($urandom_range(0, tree_count - 1));
        it.radius = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3000));
        return it;
    endfunction

    task automatic check_field(string name, logic [COST_W-1:0] exp_v, logic [COST_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Scoreboard
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, o_result);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("found", COST_W'(exp_r.found), COST_W'(o_result.found));
                check_field("node_index", COST_W'(exp_r.node_index),
                            COST_W'(o_result.node_index));
                check_field("node_x", COST_W'(exp_r.node_x), COST_W'(o_result.node_x));
                check_field("node_y", COST_W'(exp_r.node_y), COST_W'(o_result.node_y));
                check_field("node_z", COST_W'(exp_r.node_z), COST_W'(o_result.node_z));
                check_field("node_cost", exp_r.node_cost, o_result.node_cost);
                check_field("goal_reached", COST_W'(exp_r.goal_reached),
                            COST_W'(o_result.goal_reached));
                check_field("last_result", COST_W'(exp_r.last_result),
                            COST_W'(o_result.last_result));
                check_field("status", COST_W'(exp_r.status), COST_W'(o_result.status));
            end
        end
    end

    // Receiver stall pattern: switch between free-flowing, patchy and sparse pops.
    initial begin
        int mode, left;
        i_pop = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(10, 80);
            end
            left--;
            if (hold_off) i_pop = 1'b0;
            else case (mode)
                0: i_pop = 1'b1;
                1: i_pop = 1'($urandom_range(0, 1));
                default: i_pop = ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Watchdog on cycles without any accepted transfer
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_empty_tree();
        send_request(make_req(FUNC_NEAREST, 0, 0, 0, 0, 0));
        send_request(make_req(FUNC_NEAR, 0, 0, 0, 0, 65535));
        send_request(make_req(FUNC_ADD, 5, 5, 5, 0, 0));
    endtask

    task automatic test_directed_tree();
        send_request(make_req(FUNC_START, -32768, 32767, -32768, 4095, 65535));
        send_request(make_req(FUNC_ADD, 32767, -32768, 32767, 0, 0));
        send_request(make_req(FUNC_ADD, 32767, -32768, 32767, 1, 0));   // same spot: tie
        send_request(make_req(FUNC_ADD, 0, 0, 0, 3, 0));                 // bad parent
        send_request(make_req(FUNC_ADD, 0, 0, 0, 4095, 0));
        send_request(make_req(FUNC_NEAREST, 32767, -32768, 32767, 0, 0));
        send_request(make_req(FUNC_NEAREST, -32768, -32768, -32768, 0, 0));
        send_request(make_req(FUNC_NEAR, 0, 0, 0, 0, 0));               // no match
        send_request(make_req(FUNC_NEAR, 32767, -32768, 32767, 0, 65535));
        send_request(make_req(FUNC_NEAR, 32767, -32768, 32767, 0, 1));
        send_request(make_req(FUNC_START, 0, 0, 0, 0, 0));
        send_request(make_req(FUNC_ADD, 100, 0, 0, 0, 0));              // inside default goal
        send_request(make_req(FUNC_ADD, 256, 0, 0, 1, 0));              // on threshold edge
        send_request(make_req(FUNC_NEAR, 0, 0, 0, 0, 256));
    endtask

    task automatic test_goal_regs();
        wait_drained();
        write_reg(REG_GOAL_X, 16'h8000);
        write_reg(REG_GOAL_Y, 16'h7FFF);
        write_reg(REG_GOAL_Z, 16'h8000);
        write_reg(REG_GOAL_THR, 16'hFFFF);
        send_request(make_req(FUNC_ADD, -32768, 32767, -32768, 0, 0));
        send_request(make_req(FUNC_NEAREST, 0, 0, 0, 0, 0));
        wait_drained();
        write_reg(REG_GOAL_THR, 16'h0000);
        send_request(make_req(FUNC_ADD, -32768, 32767, -32768, 0, 0));
        wait_drained();
        write_reg(REG_GOAL_X, 16'h0000);
        write_reg(REG_GOAL_Y, 16'h0000);
        write_reg(REG_GOAL_Z, 16'h0000);
        write_reg(REG_GOAL_THR, 16'd1500);
    endtask

    task automatic test_random(int n);
        repeat (n) send_request(random_req());
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        repeat (12) send_request(make_req(FUNC_NEAR, 0, 0, 0, 0, 65535));
        wait_drained();
        test_random(10);
    endtask

    // Grow a tree past the near cap so a wide query truncates its list.
    task automatic test_truncation();
        send_request(make_req(FUNC_START, 0, 0, 0, 0, 0));
        for (int i = 1; i <= NEAR_CAP + 1; i++)
            send_request(make_req(FUNC_ADD, $urandom_range(0, 200), $urandom_range(0, 200),
                                  $urandom_range(0, 200), $urandom_range(0, i - 1), 0));
        send_request(make_req(FUNC_NEAREST, 100, 100, 100, 0, 0));
        send_request(make_req(FUNC_NEAR, 100, 100, 100, 0, 65535));   // truncated list
        send_request(make_req(FUNC_NEAR, -32768, -32768, -32768, 0, 2));
    endtask

    initial begin
        fail_count = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        burst_left = 0;
        tree_count = 0;
        tree_newest = 0;
        goal_px = '0; goal_py = '0; goal_pz = '0;
        goal_thr = 16'd256;
        i_push = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_tree();
        test_directed_tree();
        test_goal_regs();
        test_random(18);
        test_backpressure();
        wait_drained();
        write_reg(REG_GOAL_THR, 16'd400);
        test_random(14);
        wait_drained();
        test_truncation();

        wait_drained();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== tree_node_nearest_search_core.f =====
hdl/tnns_pkg.sv
hdl/tnns_fifo.sv
hdl/tnns_front.sv
hdl/tnns_isqrt.sv
hdl/tnns_back.sv
hdl/tree_node_nearest_search_core.sv
dv/tb_tree_node_nearest_search_core.sv
